// ===== src/assert_macros.svh =====
// Concurrent assertion helpers. Compile with SYNTH defined to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// ===== src/mts_pkg.sv =====
`default_nettype none
package mts_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int DATA_W          = 32;
   localparam int FILL_W          = 7;
   localparam int ERR_W           = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
      logic single;
   } mts_status_type;

   typedef struct packed {
      logic             push_en;
      logic             pop_en;
      logic             read_issue;
      logic             load_top;
      logic             load_rsp;
      logic [ERR_W-1:0] err_code;
   } mts_cmd_type;

endpackage
`default_nettype wire

// ===== src/mts_channels.sv =====
`default_nettype none
interface mts_req_if import mts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic signed [DATA_W-1:0] min_value;
   logic                     is_empty;
   logic [FILL_W-1:0]        fill_count;
   logic [ERR_W-1:0]         error_code;

   modport source (output valid, output top_value, output min_value, output is_empty,
                   output fill_count, output error_code, input ready);
   modport sink   (input valid, input top_value, input min_value, input is_empty,
                   input fill_count, input error_code, output ready);
endinterface
`default_nettype wire

// ===== src/mts_ram.sv =====
`default_nettype none
module mts_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/mts_ctrl.sv =====
`default_nettype none
module mts_ctrl import mts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   input  mts_status_type status,
   output mts_cmd_type    cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOAD = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.err_code = ERR_OK;
      state_in     = state_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // take a transfer once the result slot is free or draining
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               if (req_op == OP_POP) begin
                  if (status.empty) begin
                     cmd.load_rsp = 1'b1;
                     cmd.err_code = ERR_UNDERFLOW;
                  end else begin
                     cmd.pop_en = 1'b1;
                     if (status.single) begin
                        cmd.load_rsp = 1'b1;
                     end else begin
                        // fetch the new top from storage
                        cmd.read_issue = 1'b1;
                        state_in       = S_LOAD;
                     end
                  end
               end else begin
                  cmd.load_rsp = 1'b1;
                  if (status.full) begin
                     cmd.err_code = ERR_OVERFLOW;
                  end else begin
                     cmd.push_en = 1'b1;
                  end
               end
            end
         end
         S_LOAD: begin
            cmd.load_top = 1'b1;
            cmd.load_rsp = 1'b1;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== src/mts_datapath.sv =====
`default_nettype none
module mts_datapath import mts_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mts_cmd_type              cmd,
   input  logic signed [DATA_W-1:0] req_value,
   output mts_status_type           status,
   output logic signed [DATA_W-1:0] top_value,
   output logic signed [DATA_W-1:0] min_value,
   output logic                     is_empty,
   output logic [FILL_W-1:0]        fill_count,
   output logic [ERR_W-1:0]         error_code
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ENT_W  = 2 * DATA_W;

   logic [SP_W-1:0]          sp_ff, sp_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic signed [DATA_W-1:0] min_ff, min_in;

   logic signed [DATA_W-1:0] rsp_top_ff, rsp_min_ff;
   logic                     rsp_empty_ff;
   logic [FILL_W-1:0]        rsp_fill_ff;
   logic [ERR_W-1:0]         rsp_err_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ENT_W-1:0]  rd_data;

   assign status.empty  = (sp_ff == '0);
   assign status.full   = (sp_ff == SP_W'(STACK_DEPTH));
   assign status.single = (sp_ff == SP_W'(1));

   // storage holds the entries below the top; the top lives in registers
   assign wr_en   = cmd.push_en && !status.empty;
   assign wr_addr = ADDR_W'(sp_ff - SP_W'(1));
   assign rd_addr = ADDR_W'(sp_ff - SP_W'(2));

   mts_ram #(
      .WIDTH (ENT_W),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({top_ff, min_ff}),
      .rd_en   (cmd.read_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sp_in  = sp_ff;
      top_in = top_ff;
      min_in = min_ff;
      if (cmd.push_en) begin
         sp_in  = sp_ff + SP_W'(1);
         top_in = req_value;
         // keep the old minimum unless the stack is empty or the new value is strictly smaller
         if (!status.empty && !(req_value < min_ff)) begin
            min_in = min_ff;
         end else begin
            min_in = req_value;
         end
      end else if (cmd.pop_en) begin
         sp_in = sp_ff - SP_W'(1);
      end else if (cmd.load_top) begin
         top_in = $signed(rd_data[ENT_W-1:DATA_W]);
         min_in = $signed(rd_data[DATA_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      min_ff <= min_in;
      if (cmd.load_rsp) begin
         rsp_top_ff   <= (sp_in == '0) ? '0 : top_in;
         rsp_min_ff   <= (sp_in == '0) ? '0 : min_in;
         rsp_empty_ff <= (sp_in == '0);
         rsp_fill_ff  <= FILL_W'(sp_in);
         rsp_err_ff   <= cmd.err_code;
      end
   end

   assign top_value  = rsp_top_ff;
   assign min_value  = rsp_min_ff;
   assign is_empty   = rsp_empty_ff;
   assign fill_count = rsp_fill_ff;
   assign error_code = rsp_err_ff;

endmodule
`default_nettype wire

// ===== src/min_tracking_stack_top.sv =====
// Results: push, rejected operations and a pop that empties the stack show
//   their result in the cycle after the transfer; a pop that leaves entries first
//   does a registered read of the new top from the entry RAM, then loads the result.
// Throughput: one push per cycle while the result receiver keeps up; a pop that
//   leaves entries holds off the next transfer while it loads the new top.
// Reset: clears the stack pointer, the controller state and the result valid;
//   the entry RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"
module min_tracking_stack_top import mts_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   mts_req_if.sink    req_chan,
   mts_rsp_if.source  rsp_chan
);

   mts_status_type status;
   mts_cmd_type    cmd;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_chan.value),
      .status     (status),
      .top_value  (rsp_chan.top_value),
      .min_value  (rsp_chan.min_value),
      .is_empty   (rsp_chan.is_empty),
      .fill_count (rsp_chan.fill_count),
      .error_code (rsp_chan.error_code)
   );

   `ASSERT_NEXT(a_read_then_load, clock, reset, cmd.read_issue, cmd.load_top && !req_chan.ready)
   `ASSERT_IMPL(a_overflow_full, clock, reset, rsp_chan.valid && rsp_chan.error_code == ERR_OVERFLOW, rsp_chan.fill_count == FILL_W'(STACK_DEPTH))
   `ASSERT_IMPL(a_empty_zero, clock, reset, rsp_chan.valid && rsp_chan.is_empty, rsp_chan.fill_count == '0 && rsp_chan.top_value == '0 && rsp_chan.min_value == '0)
   `ASSERT_IMPL(a_min_le_top, clock, reset, rsp_chan.valid && !rsp_chan.is_empty, rsp_chan.min_value <= rsp_chan.top_value)

endmodule
`default_nettype wire

// ===== sim/tb_min_tracking_stack_top.sv =====
`default_nettype none
module tb_min_tracking_stack_top;
   import mts_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEF;
   localparam int MAX_GAP      = 13;
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic                     is_empty;
      logic [FILL_W-1:0]        fill_count;
      logic [ERR_W-1:0]         error_code;
   } stack_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mts_req_if req_chan ();
   mts_rsp_if rsp_chan ();

   min_tracking_stack_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the stack: entries and the running minimum at each depth
   logic signed [DATA_W-1:0] entry_vals [DEPTH];
   logic signed [DATA_W-1:0] floor_vals [DEPTH];
   int                       held = 0;

   stack_view_type expected_views [$];
   int             mismatches  = 0;
   int             idle_cycles = 0;
   bit             req_calm    = 1'b0;
   bit             rsp_calm    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return DATA_W'($urandom_range(0, 8)) - 32'sd4;
         default: return $urandom;
      endcase
   endfunction

   function automatic stack_view_type apply_stack_op(input logic op,
                                                     input logic signed [DATA_W-1:0] v);
      stack_view_type view;
      logic [ERR_W-1:0] err;
      err = ERR_OK;
      if (op == OP_POP) begin
         if (held == 0) err = ERR_UNDERFLOW;
         else held--;
      end else begin
         if (held >= DEPTH) begin
            err = ERR_OVERFLOW;
         end else begin
            entry_vals[held] = v;
            // minimum moves only on a strictly smaller value or on the first entry
            if (held != 0 && !($signed(v) < $signed(floor_vals[held-1])))
               floor_vals[held] = floor_vals[held-1];
            else
               floor_vals[held] = v;
            held++;
         end
      end
      view.top_value  = (held != 0) ? entry_vals[held-1] : '0;
      view.min_value  = (held != 0) ? floor_vals[held-1] : '0;
      view.is_empty   = (held == 0);
      view.fill_count = FILL_W'(held);
      view.error_code = err;
      return view;
   endfunction

   task automatic send_stack_op(input logic op, input logic signed [DATA_W-1:0] v,
                                output bit applied);
      int gap;
      stack_view_type view;
      gap = draw_gap(req_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.value <= v;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      view = apply_stack_op(op, v);
      expected_views.push_back(view);
      applied = (view.error_code == ERR_OK);
   endtask

   task automatic flag_mismatch(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch at %0t: %s expected %h got %h", $time, field, want, got);
   endtask

   // result receiver: hold ready low for a randomly drawn gap, skipped when calm, before each transfer
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         gap = draw_gap(rsp_calm);
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
      end
   end

   always @(posedge clock) begin : result_check
      stack_view_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_views.size() == 0) begin
            flag_mismatch("result with none pending, top_value", 'x, rsp_chan.top_value);
         end else begin
            want = expected_views.pop_front();
            if (rsp_chan.top_value !== want.top_value)
               flag_mismatch("top_value", want.top_value, rsp_chan.top_value);
            if (rsp_chan.min_value !== want.min_value)
               flag_mismatch("min_value", want.min_value, rsp_chan.min_value);
            if (rsp_chan.is_empty !== want.is_empty)
               flag_mismatch("is_empty", DATA_W'(want.is_empty),
                             DATA_W'(rsp_chan.is_empty));
            if (rsp_chan.fill_count !== want.fill_count)
               flag_mismatch("fill_count", DATA_W'(want.fill_count),
                             DATA_W'(rsp_chan.fill_count));
            if (rsp_chan.error_code !== want.error_code)
               flag_mismatch("error_code", DATA_W'(want.error_code),
                             DATA_W'(rsp_chan.error_code));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_pop_on_empty();
      bit ok;
      send_stack_op(OP_POP, '0, ok);
      // payload of a pop carries no meaning
      send_stack_op(OP_POP, 32'sh7FFF_FFFF, ok);
   endtask

   task automatic test_value_extremes();
      bit ok;
      send_stack_op(OP_PUSH, 32'sh7FFF_FFFF, ok);
      send_stack_op(OP_PUSH, 32'sh8000_0000, ok);
      send_stack_op(OP_PUSH, 32'sh0000_0000, ok);
      send_stack_op(OP_PUSH, -32'sd1, ok);
      send_stack_op(OP_PUSH, 32'sd1, ok);
      repeat (5) send_stack_op(OP_POP, '1, ok);
   endtask

   task automatic test_equal_minimum();
      bit ok;
      send_stack_op(OP_PUSH, 32'sd5, ok);
      send_stack_op(OP_PUSH, 32'sd5, ok);
      send_stack_op(OP_PUSH, 32'sd7, ok);
      send_stack_op(OP_PUSH, 32'sd5, ok);
      send_stack_op(OP_PUSH, 32'sd3, ok);
      send_stack_op(OP_PUSH, 32'sd3, ok);
      repeat (6) send_stack_op(OP_POP, '0, ok);
   endtask

   task automatic test_fill_to_overflow();
      bit ok;
      req_calm = ($urandom_range(0, 1) == 0);
      rsp_calm = ($urandom_range(0, 1) == 0);
      while (held < DEPTH) send_stack_op(OP_PUSH, rand_value(), ok);
      repeat (2) send_stack_op(OP_PUSH, rand_value(), ok);
      send_stack_op(OP_POP, rand_value(), ok);
      send_stack_op(OP_PUSH, rand_value(), ok);
      send_stack_op(OP_PUSH, rand_value(), ok);
      while (held > 0) send_stack_op(OP_POP, rand_value(), ok);
      send_stack_op(OP_POP, rand_value(), ok);
   endtask

   task automatic test_random_traffic(input int target);
      int done;
      int push_pct;
      bit ok;
      logic op;
      done = 0;
      while (done < target) begin
         // pick a phase: drain, hover or climb toward full
         case ($urandom_range(0, 3))
            0:       push_pct = 15;
            1:       push_pct = 50;
            2:       push_pct = 85;
            default: push_pct = 97;
         endcase
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         repeat (40) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            send_stack_op(op, rand_value(), ok);
            done++;
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op    = OP_PUSH;
      req_chan.value = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_pop_on_empty();
      test_value_extremes();
      test_equal_minimum();
      test_fill_to_overflow();
      test_random_traffic(540);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== min_tracking_stack_top.f =====
+incdir+src
src/mts_pkg.sv
src/mts_channels.sv
src/mts_ram.sv
src/mts_ctrl.sv
src/mts_datapath.sv
src/min_tracking_stack_top.sv
sim/tb_min_tracking_stack_top.sv
